[hw/rtl/bti_pkg.sv]
// Shared constants for the bilinear table interpolator and its checker.
package bti_pkg;

  // Default table geometry
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Q16.16 fraction bits
  localparam int FRAC_W = 16;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] CFG_COL_ORIGIN = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_COL_SCALE  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ROW_ORIGIN = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_ROW_SCALE  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_COLS_USED  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_ROWS_USED  = 3'd5;

  // Request types
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Cycles from the accepting edge to the edge that takes the result
  localparam int LATENCY = 8;

endpackage

[hw/rtl/bilinear_table_interpolator.sv]
// Bilinear interpolation over a banked Q16.16 sample table, fully pipelined.
//
// Usage:
//   Requests are taken on start_i while busy_o is low; busy_o never rises, so
//   one request is accepted per clock. req_type_i selects a load (write one
//   table entry, no result) or a lookup (one result).
//   A lookup result shows on interp_value_o with interp_valid_o high for one
//   cycle, at the end of the pipeline. The receiver cannot stall, and
//   no backpressure is needed since every stage advances each cycle.
//   Throughput: one item per cycle. The table is split into two memories by
//   column parity, each read at two rows per cycle, so all four neighbors
//   come out of one shared read.
//   Loads are written in the same stage where lookups read, so a lookup sees
//   exactly the loads accepted before it.
//   Configuration (origins, scales, sizes) is written through cfg_we_i. The user
//   must write it only while no lookup is in flight; the block does not enforce it.
//   Reset clears the pipeline valid flags and sets the configuration registers
//   to their defaults; table contents are undefined until loaded.
module bilinear_table_interpolator #(
  parameter int MAX_COLS = bti_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bti_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request transfer
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       req_type_i,
  input  logic [5:0]                 load_row_i,
  input  logic [5:0]                 load_col_i,
  input  logic signed [31:0]         load_value_i,
  input  logic signed [31:0]         query_col_coord_i,
  input  logic signed [31:0]         query_row_coord_i,
  // result transfer
  output logic                       interp_valid_o,
  output logic signed [31:0]         interp_value_o,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [bti_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [bti_pkg::CFG_DW-1:0] cfg_wdata_i
);

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CIDX_W     = COL_W + bti_pkg::FRAC_W;
  localparam int RIDX_W     = ROW_W + bti_pkg::FRAC_W;
  localparam int HALF_COLS  = (MAX_COLS + 1) / 2;
  localparam int BANK_DEPTH = MAX_ROWS * HALF_COLS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Configuration registers
  logic signed [31:0] col_origin_q, row_origin_q;
  logic [31:0]        col_scale_q, row_scale_q;
  logic [6:0]         cols_used_q, rows_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_origin_q <= '0;
      col_scale_q  <= 32'd65536;
      row_origin_q <= '0;
      row_scale_q  <= 32'd65536;
      cols_used_q  <= 7'd2;
      rows_used_q  <= 7'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bti_pkg::CFG_COL_ORIGIN: col_origin_q <= cfg_wdata_i;
        bti_pkg::CFG_COL_SCALE:  col_scale_q  <= cfg_wdata_i;
        bti_pkg::CFG_ROW_ORIGIN: row_origin_q <= cfg_wdata_i;
        bti_pkg::CFG_ROW_SCALE:  row_scale_q  <= cfg_wdata_i;
        bti_pkg::CFG_COLS_USED:  cols_used_q  <= cfg_wdata_i[6:0];
        bti_pkg::CFG_ROWS_USED:  rows_used_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Sizes saturated to [2, MAX], minus one; index ceilings in Q16.16
  logic [31:0]       cu_ext, ru_ext;
  logic [COL_W-1:0]  ncols_m1;
  logic [ROW_W-1:0]  nrows_m1;
  logic [CIDX_W-1:0] col_top;
  logic [RIDX_W-1:0] row_top;

  always_comb begin
    cu_ext = 32'(cols_used_q);
    ru_ext = 32'(rows_used_q);
    if (cu_ext < 32'd2) begin
      ncols_m1 = COL_W'(1);
    end else if (cu_ext > 32'(MAX_COLS)) begin
      ncols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      ncols_m1 = COL_W'(cu_ext - 32'd1);
    end
    if (ru_ext < 32'd2) begin
      nrows_m1 = ROW_W'(1);
    end else if (ru_ext > 32'(MAX_ROWS)) begin
      nrows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      nrows_m1 = ROW_W'(ru_ext - 32'd1);
    end
    col_top = {ncols_m1, {bti_pkg::FRAC_W{1'b0}}} - CIDX_W'(1);
    row_top = {nrows_m1, {bti_pkg::FRAC_W{1'b0}}} - RIDX_W'(1);
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------- Stage 1: origin subtraction, load check ----------------
  logic signed [32:0] col_diff, row_diff;
  logic               load_ok;

  assign col_diff = 33'(query_col_coord_i) - 33'(col_origin_q);
  assign row_diff = 33'(query_row_coord_i) - 33'(row_origin_q);
  assign load_ok  = (32'(load_row_i) < 32'(MAX_ROWS)) && (32'(load_col_i) < 32'(MAX_COLS));

  logic               s1_vld_q, s1_load_q, s1_lok_q;
  logic [5:0]         s1_lrow_q, s1_lcol_q;
  logic [31:0]        s1_lval_q;
  logic [31:0]        s1_cdist_q, s1_rdist_q;

  // ---------------- Stage 2: split products ----------------
  logic               s2_vld_q, s2_load_q, s2_lok_q;
  logic [5:0]         s2_lrow_q, s2_lcol_q;
  logic [31:0]        s2_lval_q;
  logic [47:0]        s2_chi_q, s2_clo_q, s2_rhi_q, s2_rlo_q;

  // ---------------- Stage 3: sum and clamp ----------------
  logic [48:0]        col_sum, row_sum;
  logic [CIDX_W-1:0]  col_idx_d;
  logic [RIDX_W-1:0]  row_idx_d;

  assign col_sum = 49'(s2_chi_q) + 49'(s2_clo_q[47:16]);
  assign row_sum = 49'(s2_rhi_q) + 49'(s2_rlo_q[47:16]);

  always_comb begin
    col_idx_d = (col_sum > 49'(col_top)) ? col_top : col_sum[CIDX_W-1:0];
    row_idx_d = (row_sum > 49'(row_top)) ? row_top : row_sum[RIDX_W-1:0];
  end

  logic               s3_vld_q, s3_load_q, s3_lok_q;
  logic [5:0]         s3_lrow_q, s3_lcol_q;
  logic [31:0]        s3_lval_q;
  logic [CIDX_W-1:0]  s3_cidx_q;
  logic [RIDX_W-1:0]  s3_ridx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Front pipeline payload
  always_ff @(posedge clk_i) begin
    s1_load_q  <= (req_type_i == bti_pkg::REQ_LOAD);
    s1_lok_q   <= load_ok;
    s1_lrow_q  <= load_row_i;
    s1_lcol_q  <= load_col_i;
    s1_lval_q  <= load_value_i;
    // non-positive distance maps to index zero
    s1_cdist_q <= col_diff[32] ? '0 : col_diff[31:0];
    s1_rdist_q <= row_diff[32] ? '0 : row_diff[31:0];

    s2_load_q  <= s1_load_q;
    s2_lok_q   <= s1_lok_q;
    s2_lrow_q  <= s1_lrow_q;
    s2_lcol_q  <= s1_lcol_q;
    s2_lval_q  <= s1_lval_q;
    s2_chi_q   <= 48'(s1_cdist_q) * 48'(col_scale_q[31:16]);
    s2_clo_q   <= 48'(s1_cdist_q) * 48'(col_scale_q[15:0]);
    s2_rhi_q   <= 48'(s1_rdist_q) * 48'(row_scale_q[31:16]);
    s2_rlo_q   <= 48'(s1_rdist_q) * 48'(row_scale_q[15:0]);

    s3_load_q  <= s2_load_q;
    s3_lok_q   <= s2_lok_q;
    s3_lrow_q  <= s2_lrow_q;
    s3_lcol_q  <= s2_lcol_q;
    s3_lval_q  <= s2_lval_q;
    s3_cidx_q  <= col_idx_d;
    s3_ridx_q  <= row_idx_d;
  end

  // ---------------- Stage 4: bank addressing and table access ----------------
  logic [COL_W-1:0]   ci;
  logic [COL_W:0]     ci_p1;
  logic [ROW_W-1:0]   ri, ri_p1;
  logic [BANK_AW-1:0] even_half, odd_half, row0_base, row1_base;
  logic [BANK_AW-1:0] even_a0, even_a1, odd_a0, odd_a1;
  logic [COL_W-1:0]   lcol;
  logic [ROW_W-1:0]   lrow;
  logic [BANK_AW-1:0] waddr;
  logic               wr_en, we_even, we_odd;

  always_comb begin
    ci        = s3_cidx_q[CIDX_W-1:bti_pkg::FRAC_W];
    ri        = s3_ridx_q[RIDX_W-1:bti_pkg::FRAC_W];
    ci_p1     = {1'b0, ci} + (COL_W+1)'(1);
    ri_p1     = ri + ROW_W'(1);
    // even column of the pair is (ci+1)/2, odd column is ci/2
    even_half = BANK_AW'(ci_p1 >> 1);
    odd_half  = BANK_AW'(ci >> 1);
    row0_base = BANK_AW'(ri) * BANK_AW'(HALF_COLS);
    row1_base = BANK_AW'(ri_p1) * BANK_AW'(HALF_COLS);
    even_a0   = row0_base + even_half;
    even_a1   = row1_base + even_half;
    odd_a0    = row0_base + odd_half;
    odd_a1    = row1_base + odd_half;
    // load write port
    lcol      = COL_W'(s3_lcol_q);
    lrow      = ROW_W'(s3_lrow_q);
    waddr     = BANK_AW'(lrow) * BANK_AW'(HALF_COLS) + BANK_AW'(lcol >> 1);
    wr_en     = s3_vld_q && s3_load_q && s3_lok_q;
    we_even   = wr_en && !lcol[0];
    we_odd    = wr_en && lcol[0];
  end

  logic [31:0] mem_even [BANK_DEPTH];
  logic [31:0] mem_odd  [BANK_DEPTH];
  logic [31:0] even_rd0_q, even_rd1_q, odd_rd0_q, odd_rd1_q;

  // Even-column bank: one write, two reads
  always_ff @(posedge clk_i) begin
    if (we_even) begin
      mem_even[waddr] <= s3_lval_q;
    end
    even_rd0_q <= mem_even[even_a0];
    even_rd1_q <= mem_even[even_a1];
  end

  // Odd-column bank: one write, two reads
  always_ff @(posedge clk_i) begin
    if (we_odd) begin
      mem_odd[waddr] <= s3_lval_q;
    end
    odd_rd0_q <= mem_odd[odd_a0];
    odd_rd1_q <= mem_odd[odd_a1];
  end

  logic        s4_vld_q, s4_codd_q;
  logic [15:0] s4_cf_q, s4_rf_q;

  // ---------------- Stage 5: row-direction lerp products ----------------
  logic signed [31:0] x00, x01, x10, x11;
  logic signed [32:0] dl, dr;
  logic signed [16:0] rf_s;

  always_comb begin
    if (s4_codd_q) begin
      x00 = odd_rd0_q;
      x01 = odd_rd1_q;
      x10 = even_rd0_q;
      x11 = even_rd1_q;
    end else begin
      x00 = even_rd0_q;
      x01 = even_rd1_q;
      x10 = odd_rd0_q;
      x11 = odd_rd1_q;
    end
    dl   = 33'(x01) - 33'(x00);
    dr   = 33'(x11) - 33'(x10);
    rf_s = $signed({1'b0, s4_rf_q});
  end

  logic               s5_vld_q;
  logic [15:0]        s5_cf_q;
  logic signed [31:0] s5_a0_q, s5_a1_q;
  logic signed [49:0] s5_pl_q, s5_pr_q;

  // ---------------- Stage 6: left and right values ----------------
  // arithmetic shift of the product is the floor division by 2^16
  logic signed [49:0] left_d, right_d;

  assign left_d  = 50'(s5_a0_q) + (s5_pl_q >>> bti_pkg::FRAC_W);
  assign right_d = 50'(s5_a1_q) + (s5_pr_q >>> bti_pkg::FRAC_W);

  logic               s6_vld_q;
  logic [15:0]        s6_cf_q;
  logic signed [31:0] s6_left_q, s6_right_q;

  // ---------------- Stage 7: column-direction lerp product ----------------
  logic signed [32:0] dc;
  logic signed [16:0] cf_s;

  assign dc   = 33'(s6_right_q) - 33'(s6_left_q);
  assign cf_s = $signed({1'b0, s6_cf_q});

  logic               s7_vld_q;
  logic signed [31:0] s7_left_q;
  logic signed [49:0] s7_pc_q;

  // ---------------- Stage 8: final value ----------------
  // a lerp stays between its end points, so the result always fits 32 bits
  logic signed [49:0] value_d;

  assign value_d = 50'(s7_left_q) + (s7_pc_q >>> bti_pkg::FRAC_W);

  logic               out_vld_q;
  logic signed [31:0] out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s4_vld_q  <= s3_vld_q && !s3_load_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      out_vld_q <= s7_vld_q;
    end
  end

  // Back pipeline payload
  always_ff @(posedge clk_i) begin
    s4_codd_q  <= ci[0];
    s4_cf_q    <= s3_cidx_q[bti_pkg::FRAC_W-1:0];
    s4_rf_q    <= s3_ridx_q[bti_pkg::FRAC_W-1:0];

    s5_cf_q    <= s4_cf_q;
    s5_a0_q    <= x00;
    s5_a1_q    <= x10;
    s5_pl_q    <= 50'(rf_s) * 50'(dl);
    s5_pr_q    <= 50'(rf_s) * 50'(dr);

    s6_cf_q    <= s5_cf_q;
    s6_left_q  <= left_d[31:0];
    s6_right_q <= right_d[31:0];

    s7_left_q  <= s6_left_q;
    s7_pc_q    <= 50'(cf_s) * 50'(dc);

    out_val_q  <= value_d[31:0];
  end

  assign interp_valid_o = out_vld_q;
  assign interp_value_o = out_val_q;

endmodule

[hw/rtl/bti_checker.sv]
// Port-level assertions for the bilinear table interpolator, with its bind.
module bti_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic req_type_i,
  input logic interp_valid_o
);

  logic lookup_acc, load_acc;

  assign lookup_acc = start_i && !busy_o && (req_type_i == bti_pkg::REQ_LOOKUP);
  assign load_acc   = start_i && !busy_o && (req_type_i == bti_pkg::REQ_LOAD);

  // every accepted lookup yields a strobe after the fixed latency
  a_lookup_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc |-> ##(bti_pkg::LATENCY) interp_valid_o)
    else $error("lookup produced no result at the expected cycle");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |-> ##(bti_pkg::LATENCY) !interp_valid_o)
    else $error("load produced a result strobe");

  // no strobe without a matching lookup
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    interp_valid_o |-> $past(lookup_acc, bti_pkg::LATENCY))
    else $error("result strobe without a lookup");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .req_type_i     (req_type_i),
  .interp_valid_o (interp_valid_o)
);

[sim/bti_checker.sv]
// Checker for the bilinear table interpolator: tracks table and registers, predicts, compares.
module bti_tb_checker #(
  parameter int MAX_COLS = bti_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bti_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request transfer
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        req_type_i,
  input  logic [5:0]                  load_row_i,
  input  logic [5:0]                  load_col_i,
  input  logic signed [31:0]          load_value_i,
  input  logic signed [31:0]          query_col_coord_i,
  input  logic signed [31:0]          query_row_coord_i,
  // result transfer
  input  logic                        interp_valid_i,
  input  logic signed [31:0]          interp_value_i,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [bti_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [bti_pkg::CFG_DW-1:0]  cfg_wdata_i,
  // status toward the top
  output int                          mismatch_count_o,
  output int                          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the sample table and the grid registers
  logic signed [31:0] sample_mem [MAX_ROWS*MAX_COLS];
  logic signed [31:0] col_base;
  logic [31:0]        col_step;
  logic signed [31:0] row_base;
  logic [31:0]        row_step;
  logic [6:0]         cols_raw;
  logic [6:0]         rows_raw;

  logic signed [31:0] interp_expected [$];
  logic signed [31:0] oldest;
  int                 mismatches = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] interp check: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned grid_size(logic [6:0] n, int unsigned limit);
    if (n < 2) return 2;
    if (n > limit) return limit;
    return n;
  endfunction

  // Q16.16 fractional index, clamped so the upper neighbor stays in the grid
  function automatic logic [63:0] grid_index(logic signed [31:0] coord,
                                             logic signed [31:0] base,
                                             logic [31:0] step, int unsigned size);
    longint      delta;
    logic [63:0] prod;
    logic [63:0] top;
    delta = longint'(coord) - longint'(base);
    top   = ({32'd0, 32'(size - 1)} << bti_pkg::FRAC_W) - 64'd1;
    if (delta <= 0) return 64'd0;
    prod = ({32'd0, delta[31:0]} * {32'd0, step}) >> bti_pkg::FRAC_W;
    return (prod > top) ? top : prod;
  endfunction

  // a + floor(f * (b - a) / 2^16)
  function automatic longint blend(longint a, longint b, logic [15:0] f);
    longint prod;
    prod = longint'(f) * (b - a);
    return a + (prod >>> bti_pkg::FRAC_W);
  endfunction

  function automatic longint sample_at(int unsigned r, int unsigned c);
    return longint'(sample_mem[r*MAX_COLS + c]);
  endfunction

  function automatic logic signed [31:0] interp_lookup(logic signed [31:0] col_coord,
                                                       logic signed [31:0] row_coord);
    int unsigned ncols, nrows, ci, ri;
    logic [63:0] cidx, ridx;
    longint      left, right, val;
    ncols = grid_size(cols_raw, MAX_COLS);
    nrows = grid_size(rows_raw, MAX_ROWS);
    cidx  = grid_index(col_coord, col_base, col_step, ncols);
    ridx  = grid_index(row_coord, row_base, row_step, nrows);
    ci    = cidx[47:16];
    ri    = ridx[47:16];
    // along the rows for both columns, then across the columns
    left  = blend(sample_at(ri, ci), sample_at(ri + 1, ci), ridx[15:0]);
    right = blend(sample_at(ri, ci + 1), sample_at(ri + 1, ci + 1), ridx[15:0]);
    val   = blend(left, right, cidx[15:0]);
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    return val[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_base = '0;
      col_step = 32'd65536;
      row_base = '0;
      row_step = 32'd65536;
      cols_raw = 7'd2;
      rows_raw = 7'd2;
      interp_expected.delete();
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bti_pkg::CFG_COL_ORIGIN: col_base = cfg_wdata_i;
          bti_pkg::CFG_COL_SCALE:  col_step = cfg_wdata_i;
          bti_pkg::CFG_ROW_ORIGIN: row_base = cfg_wdata_i;
          bti_pkg::CFG_ROW_SCALE:  row_step = cfg_wdata_i;
          bti_pkg::CFG_COLS_USED:  cols_raw = cfg_wdata_i[6:0];
          bti_pkg::CFG_ROWS_USED:  rows_raw = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (interp_valid_i) begin
        if (interp_expected.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", interp_value_i));
        end else begin
          oldest = interp_expected.pop_front();
          if (interp_value_i !== oldest)
            report_mismatch($sformatf("interp_value got %h expected %h",
                                      interp_value_i, oldest));
        end
      end
      // request transfer
      if (start_i && !busy_i) begin
        if (req_type_i == bti_pkg::REQ_LOAD) begin
          if (load_row_i < MAX_ROWS && load_col_i < MAX_COLS)
            sample_mem[int'(load_row_i)*MAX_COLS + int'(load_col_i)] = load_value_i;
        end else begin
          interp_expected = {interp_expected,
                             interp_lookup(query_col_coord_i, query_row_coord_i)};
        end
      end
      pending_o <= interp_expected.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the bilinear table interpolator: clock, reset, stimulus and verdict.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 20;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  logic                       req_type_i = bti_pkg::REQ_LOAD;
  logic [5:0]                 load_row_i = '0;
  logic [5:0]                 load_col_i = '0;
  logic signed [31:0]         load_value_i = '0;
  logic signed [31:0]         query_col_coord_i = '0;
  logic signed [31:0]         query_row_coord_i = '0;
  logic                       interp_valid_o;
  logic signed [31:0]         interp_value_o;
  logic                       cfg_we_i = 1'b0;
  logic [bti_pkg::CFG_AW-1:0] cfg_addr_i = '0;
  logic [bti_pkg::CFG_DW-1:0] cfg_wdata_i = '0;

  int mismatch_count;
  int pending_count;
  int stall_cycles = 0;
  bit steady = 1'b0;

  // Grid setting currently programmed, used to aim the coordinates
  logic [31:0] col_org = '0;
  logic [31:0] col_scl = 32'd65536;
  logic [31:0] row_org = '0;
  logic [31:0] row_scl = 32'd65536;
  int          ncols_eff = 2;
  int          nrows_eff = 2;

  bilinear_table_interpolator u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .req_type_i        (req_type_i),
    .load_row_i        (load_row_i),
    .load_col_i        (load_col_i),
    .load_value_i      (load_value_i),
    .query_col_coord_i (query_col_coord_i),
    .query_row_coord_i (query_row_coord_i),
    .interp_valid_o    (interp_valid_o),
    .interp_value_o    (interp_value_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  bti_tb_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .req_type_i        (req_type_i),
    .load_row_i        (load_row_i),
    .load_col_i        (load_col_i),
    .load_value_i      (load_value_i),
    .query_col_coord_i (query_col_coord_i),
    .query_row_coord_i (query_row_coord_i),
    .interp_valid_i    (interp_valid_o),
    .interp_value_i    (interp_value_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || interp_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int fit_size(logic [6:0] n);
    if (n < 2) return 2;
    if (n > 64) return 64;
    return n;
  endfunction

  function automatic logic [31:0] sample_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly inside the grid span, with some below origin, wild and extreme coordinates
  function automatic logic [31:0] make_coord(logic [31:0] org, logic [31:0] scl, int size);
    logic [63:0] span;
    logic [63:0] pick;
    longint      sum;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return org - $urandom_range(1, 32'h00FF_FFFF);
      2: begin
        case ($urandom_range(0, 2))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          default: return org;
        endcase
      end
      default: begin
        if (scl == 0) span = 64'h1_0000_0000;
        else span = ({32'd0, 32'(size - 1)} << 32) / {32'd0, scl};
        span = span + (span >> 3) + 64'd1;
        pick = {$urandom, $urandom} % span;
        sum  = longint'($signed(org)) + longint'(pick);
        return sum[31:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_scale(int size);
    logic [63:0] span, scl;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd65536;
      3: return $urandom;
      default: begin
        // (size-1)/(max-min) for a random coordinate span
        span = $urandom_range(32'h0000_0100, 32'h0100_0000);
        scl  = ({32'd0, 32'(size - 1)} << 32) / span;
        return (scl > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scl[31:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  // One request transfer; each cycle in front of it idles at random unless steady is set
  task automatic issue(logic kind, logic [5:0] row, logic [5:0] col,
                       logic [31:0] value, logic [31:0] ccoord, logic [31:0] rcoord);
    while (!steady && $urandom_range(0, 99) < 19) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i           <= 1'b1;
    req_type_i        <= kind;
    load_row_i        <= row;
    load_col_i        <= col;
    load_value_i      <= value;
    query_col_coord_i <= ccoord;
    query_row_coord_i <= rcoord;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic load_entry(int row, int col, logic [31:0] value);
    issue(bti_pkg::REQ_LOAD, row[5:0], col[5:0], value, $urandom, $urandom);
  endtask

  task automatic lookup(logic [31:0] ccoord, logic [31:0] rcoord);
    issue(bti_pkg::REQ_LOOKUP, 6'($urandom), 6'($urandom), $urandom, ccoord, rcoord);
  endtask

  task automatic write_reg(logic [bti_pkg::CFG_AW-1:0] addr, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Drain the pipeline, then reprogram the whole grid
  task automatic program_grid(logic [31:0] c_org, logic [31:0] c_scl,
                              logic [31:0] r_org, logic [31:0] r_scl,
                              logic [6:0] cols, logic [6:0] rows);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (bti_pkg::LATENCY + 2) @(posedge clk_i);
    write_reg(bti_pkg::CFG_COL_ORIGIN, c_org);
    write_reg(bti_pkg::CFG_COL_SCALE, c_scl);
    write_reg(bti_pkg::CFG_ROW_ORIGIN, r_org);
    write_reg(bti_pkg::CFG_ROW_SCALE, r_scl);
    write_reg(bti_pkg::CFG_COLS_USED, {25'd0, cols});
    write_reg(bti_pkg::CFG_ROWS_USED, {25'd0, rows});
    cfg_we_i  <= 1'b0;
    col_org   = c_org;
    col_scl   = c_scl;
    row_org   = r_org;
    row_scl   = r_scl;
    ncols_eff = fit_size(cols);
    nrows_eff = fit_size(rows);
  endtask

  // Every entry a lookup can reach gets written before any lookup
  task automatic fill_grid();
    for (int r = 0; r < nrows_eff; r++)
      for (int c = 0; c < ncols_eff; c++)
        load_entry(r, c, sample_value());
  endtask

  initial begin
    logic [6:0]  cols, rows;
    logic [31:0] c_org, r_org, c_scl, r_scl;
    int          row, col;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset grid (2x2, unit scale, origin 0), extreme samples
    load_entry(0, 0, 32'h7FFF_FFFF);
    load_entry(1, 0, 32'h8000_0000);
    load_entry(0, 1, 32'h0000_0000);
    load_entry(1, 1, 32'hFFFF_FFFF);
    load_entry(63, 63, 32'h5A5A_A5A5);
    lookup(32'h0000_0000, 32'h0000_0000);
    lookup(32'h0000_8000, 32'h0000_8000);
    lookup(32'h0000_4000, 32'h0000_C000);
    lookup(32'h0000_FFFF, 32'h0000_FFFF);
    lookup(32'h0001_0000, 32'h0001_0000);
    lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    lookup(32'h8000_0000, 32'h8000_0000);
    lookup(32'hFFFF_FFFF, 32'h0000_0001);
    lookup(32'h0000_0001, 32'h7FFF_FFFF);
    // a lookup right behind the load it depends on
    load_entry(0, 0, 32'h8000_0000);
    lookup(32'h0000_0000, 32'h0000_0000);
    load_entry(1, 1, 32'h7FFF_FFFF);
    lookup(32'h0000_8000, 32'h0000_8000);
    lookup(32'h0000_7FFF, 32'h0000_0001);

    // Random phases, each with its own grid setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        // sizes beyond both ends saturate to the full width and the minimum
        0: begin cols = 7'd127; rows = 7'd0;   end
        1: begin cols = 7'd1;   rows = 7'd127; end
        default: begin
          cols = 7'($urandom_range(2, 4));
          rows = 7'($urandom_range(2, 4));
        end
      endcase
      c_org = pick_origin();
      r_org = pick_origin();
      c_scl = pick_scale(fit_size(cols));
      r_scl = pick_scale(fit_size(rows));
      // scale and origin extremes
      if (p == 2) begin c_scl = 32'd0;          r_scl = 32'hFFFF_FFFF; end
      if (p == 3) begin c_scl = 32'hFFFF_FFFF;  r_scl = 32'd0;         end
      if (p == 4) begin c_org = 32'h8000_0000;  r_org = 32'h7FFF_FFFF; end
      program_grid(c_org, c_scl, r_org, r_scl, cols, rows);
      steady = (p == 1);
      fill_grid();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 80) begin
          lookup(make_coord(col_org, col_scl, ncols_eff),
                 make_coord(row_org, row_scl, nrows_eff));
        end else begin
          row = $urandom_range(0, 1) ? $urandom_range(0, nrows_eff - 1) : $urandom_range(0, 63);
          col = $urandom_range(0, 1) ? $urandom_range(0, ncols_eff - 1) : $urandom_range(0, 63);
          load_entry(row, col, sample_value());
        end
      end
    end

    // Drain and give the verdict
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (bti_pkg::LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
